// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file pfe_checker.
// ----------------------------------------------------------------------------
// Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled during reset.
`define PFE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form: antecedent, then consequent in the cycle after.
`define PFE_ASSERT_NEXT(name, ante, cons, msg) \
  `PFE_ASSERT(name, (ante) |=> (cons), msg)

`endif

// ===== src/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// Types, constants and key-square tables of the Playfair stream encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned SquareSide = 5;

  // Letter indexes, A = 0
  localparam logic [4:0] LetterI = 5'd8;
  localparam logic [4:0] LetterJ = 5'd9;
  localparam logic [4:0] LetterX = 5'd23;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } cell_t;

  typedef struct packed {
    cell_t a;
    cell_t b;
    logic  last;
  } pair_t;

  // Up to two pairs pushed by the front in one cycle, in order
  typedef struct packed {
    logic [1:0] cnt;
    pair_t      p0;
    pair_t      p1;
  } push_t;

  // Key square, row-major, ASCII codes
  localparam logic [6:0] KeySquare [SquareSide*SquareSide] = '{
    7'd77, 7'd70, 7'd72, 7'd73, 7'd75,
    7'd85, 7'd78, 7'd79, 7'd80, 7'd81,
    7'd90, 7'd86, 7'd87, 7'd88, 7'd89,
    7'd69, 7'd76, 7'd65, 7'd82, 7'd71,
    7'd68, 7'd83, 7'd84, 7'd66, 7'd67
  };

  // Position of a letter in the key square (J shares the cell of I)
  function automatic cell_t cell_of(input logic [4:0] idx);
    cell_t c;
    case (idx)
      5'd0:    c = '{row: 3'd3, col: 3'd2};
      5'd1:    c = '{row: 3'd4, col: 3'd3};
      5'd2:    c = '{row: 3'd4, col: 3'd4};
      5'd3:    c = '{row: 3'd4, col: 3'd0};
      5'd4:    c = '{row: 3'd3, col: 3'd0};
      5'd5:    c = '{row: 3'd0, col: 3'd1};
      5'd6:    c = '{row: 3'd3, col: 3'd4};
      5'd7:    c = '{row: 3'd0, col: 3'd2};
      5'd8:    c = '{row: 3'd0, col: 3'd3};
      5'd9:    c = '{row: 3'd0, col: 3'd3};
      5'd10:   c = '{row: 3'd0, col: 3'd4};
      5'd11:   c = '{row: 3'd3, col: 3'd1};
      5'd12:   c = '{row: 3'd0, col: 3'd0};
      5'd13:   c = '{row: 3'd1, col: 3'd1};
      5'd14:   c = '{row: 3'd1, col: 3'd2};
      5'd15:   c = '{row: 3'd1, col: 3'd3};
      5'd16:   c = '{row: 3'd1, col: 3'd4};
      5'd17:   c = '{row: 3'd3, col: 3'd3};
      5'd18:   c = '{row: 3'd4, col: 3'd1};
      5'd19:   c = '{row: 3'd4, col: 3'd2};
      5'd20:   c = '{row: 3'd1, col: 3'd0};
      5'd21:   c = '{row: 3'd2, col: 3'd1};
      5'd22:   c = '{row: 3'd2, col: 3'd2};
      5'd23:   c = '{row: 3'd2, col: 3'd3};
      5'd24:   c = '{row: 3'd2, col: 3'd4};
      5'd25:   c = '{row: 3'd2, col: 3'd0};
      default: c = '{row: 3'd0, col: 3'd0};
    endcase
    return c;
  endfunction

  // ASCII letter at a square position
  function automatic logic [6:0] letter_at(input cell_t c);
    logic [4:0] k;
    k = 5'({c.row, 2'b00}) + 5'(c.row) + 5'(c.col);
    return KeySquare[k];
  endfunction

  // Step one place along a row or column, wrapping at the edge
  function automatic logic [2:0] step_wrap(input logic [2:0] v);
    return (v == 3'(SquareSide - 1)) ? 3'd0 : 3'(v + 3'd1);
  endfunction

endpackage

// ===== src/pfe_front.sv =====
// ----------------------------------------------------------------------------
// pfe_front
// Accepts text bytes, folds letters, tracks the pending letter and forms
// plaintext pairs as square positions.
// ----------------------------------------------------------------------------
module pfe_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     char_code_i,
  input  logic           end_of_text_i,
  output pfe_pkg::push_t push_o
);
  import pfe_pkg::*;

  localparam logic [7:0] AsciiUpperA = 8'd65;
  localparam logic [7:0] AsciiUpperZ = 8'd90;
  localparam logic [7:0] AsciiLowerA = 8'd97;
  localparam logic [7:0] AsciiLowerZ = 8'd122;

  logic [4:0] pend_q, pend_d;
  logic       pend_vld_q, pend_vld_d;

  logic       is_letter;
  logic [4:0] idx_raw, idx;
  logic       pair_a_vld, pair_b_vld;
  pair_t      pair_a, pair_b;

  always_comb begin
    is_letter = 1'b0;
    idx_raw   = '0;
    if (char_code_i inside {[AsciiLowerA:AsciiLowerZ]}) begin
      is_letter = 1'b1;
      idx_raw   = 5'(char_code_i - AsciiLowerA);
    end else if (char_code_i inside {[AsciiUpperA:AsciiUpperZ]}) begin
      is_letter = 1'b1;
      idx_raw   = 5'(char_code_i - AsciiUpperA);
    end
    idx = (idx_raw == LetterJ) ? LetterI : idx_raw;
  end

  always_comb begin
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    pair_a_vld = 1'b0;
    pair_b_vld = 1'b0;
    pair_a     = '{a: cell_of(pend_q), b: cell_of(idx), last: 1'b0};
    pair_b     = '{a: cell_of(pend_q), b: cell_of(LetterX), last: 1'b1};

    if (accept_i && is_letter) begin
      if (!pend_vld_q) begin
        pend_d     = idx;
        pend_vld_d = 1'b1;
      end else if (pend_q == idx) begin
        // repeat: pad with X, letter stays pending
        pair_a_vld = 1'b1;
        pair_a.b   = cell_of(LetterX);
      end else begin
        pair_a_vld = 1'b1;
        pend_vld_d = 1'b0;
        pend_d     = '0;
      end
    end

    if (accept_i && end_of_text_i && pend_vld_d) begin
      pair_b_vld = 1'b1;
      pair_b.a   = cell_of(pend_d);
      pend_vld_d = 1'b0;
      pend_d     = '0;
    end

    pair_a.last = !pair_b_vld;

    push_o = '{cnt: 2'd0, p0: pair_a, p1: pair_b};
    if (pair_a_vld && pair_b_vld) begin
      push_o.cnt = 2'd2;
    end else if (pair_a_vld) begin
      push_o.cnt = 2'd1;
    end else if (pair_b_vld) begin
      push_o.cnt = 2'd1;
      push_o.p0  = pair_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
    end
  end

endmodule

// ===== src/pfe_queue.sv =====
// ----------------------------------------------------------------------------
// pfe_queue
// Pair queue between front and back: two writes and one read per cycle.
// ----------------------------------------------------------------------------
module pfe_queue #(
  parameter int unsigned Depth = 4  // power of two, at least 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pfe_pkg::push_t push_i,
  output logic           space_o,
  input  logic           pop_i,
  output logic           head_vld_o,
  output pfe_pkg::pair_t head_o
);
  import pfe_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  pair_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [PtrW-1:0]  wr_ptr_nxt;

  assign wr_ptr_nxt = PtrW'(wr_ptr_q + 1'b1);
  assign space_o    = (count_q <= CntW'(Depth - 2));
  assign head_vld_o = (count_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = PtrW'(wr_ptr_q + PtrW'(push_i.cnt));
    rd_ptr_d = pop_i ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = CntW'(count_q + CntW'(push_i.cnt) - CntW'(pop_i));
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.p0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.p1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== src/pfe_back.sv =====
// ----------------------------------------------------------------------------
// pfe_back
// Applies the Playfair pair rules to the queue head and holds the result
// in the output register.
// ----------------------------------------------------------------------------
module pfe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_vld_i,
  input  pfe_pkg::pair_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [6:0]     first_letter_o,
  output logic [6:0]     second_letter_o,
  output logic           last_of_run_o
);
  import pfe_pkg::*;

  logic       out_vld_q;
  logic [6:0] first_q, second_q;
  logic       last_q;
  cell_t      enc_a, enc_b;

  always_comb begin
    if (head_i.a.row == head_i.b.row) begin
      enc_a = '{row: head_i.a.row, col: step_wrap(head_i.a.col)};
      enc_b = '{row: head_i.b.row, col: step_wrap(head_i.b.col)};
    end else if (head_i.a.col == head_i.b.col) begin
      enc_a = '{row: step_wrap(head_i.a.row), col: head_i.a.col};
      enc_b = '{row: step_wrap(head_i.b.row), col: head_i.b.col};
    end else begin
      // rectangle: keep rows, swap columns
      enc_a = '{row: head_i.a.row, col: head_i.b.col};
      enc_b = '{row: head_i.b.row, col: head_i.a.col};
    end
  end

  assign pop_o = head_vld_i && (!out_vld_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || !out_stall_i) begin
      out_vld_q <= head_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      first_q  <= letter_at(enc_a);
      second_q <= letter_at(enc_b);
      last_q   <= head_i.last;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign first_letter_o  = first_q;
  assign second_letter_o = second_q;
  assign last_of_run_o   = last_q;

endmodule

// ===== src/playfair_stream_encryptor_core.sv =====
// ----------------------------------------------------------------------------
// playfair_stream_encryptor_core
// Playfair encryptor over a byte stream with a fixed 5x5 key square.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o | char_code_i, end_of_text_i
//  out     | output    | out_valid_o/out_stall_i | first_letter_o, second_letter_o,
//          |           |                        | last_of_run_o
//
// One text byte is taken per cycle unless in_stall_o is high; each pair
// passes the pair queue and the output register. The back end delivers one pair
// per cycle unless out_stall_i is high; the queue absorbs an item's second pair.
// in_stall_o rises when the queue has fewer than two free entries.
// Reset clears the pending letter and empties the queue and output register.
// ----------------------------------------------------------------------------
module playfair_stream_encryptor_core #(
  parameter int unsigned QueueDepth = 4  // power of two, at least 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] first_letter_o,
  output logic [6:0] second_letter_o,
  output logic       last_of_run_o
);
  import pfe_pkg::*;

  push_t push;
  pair_t head;
  logic  head_vld;
  logic  space;
  logic  pop;
  logic  accept;

  assign in_stall_o = !space;
  assign accept     = in_valid_i && space;

  pfe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push)
  );

  pfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_o    (space),
    .pop_i      (pop),
    .head_vld_o (head_vld),
    .head_o     (head)
  );

  pfe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_vld_i      (head_vld),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .first_letter_o  (first_letter_o),
    .second_letter_o (second_letter_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

// ===== src/pfe_checker.sv =====
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks of the Playfair stream encryptor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] first_letter_o,
  input logic [6:0] second_letter_o,
  input logic       last_of_run_o
);

  localparam logic [6:0] AsciiUpperA = 7'd65;
  localparam logic [6:0] AsciiUpperZ = 7'd90;
  localparam logic [6:0] AsciiUpperJ = 7'd74;

  logic        out_fire;
  logic        out_held;
  logic        out_idle;
  logic        letters_ok;
  logic [14:0] out_word;

  assign out_fire = out_valid_o && !out_stall_i;
  assign out_held = out_valid_o && out_stall_i;
  assign out_idle = !out_valid_o;
  assign out_word = {first_letter_o, second_letter_o, last_of_run_o};

  // ciphertext is uppercase and never J
  assign letters_ok = (first_letter_o >= AsciiUpperA) && (first_letter_o <= AsciiUpperZ) &&
                      (first_letter_o != AsciiUpperJ) &&
                      (second_letter_o >= AsciiUpperA) && (second_letter_o <= AsciiUpperZ) &&
                      (second_letter_o != AsciiUpperJ);

  // stalled result holds
  `PFE_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_word), "held result changed")

  `PFE_ASSERT(a_letters, out_valid_o |-> letters_ok, "result letter out of range")

  // the second pair of a run follows directly
  `PFE_ASSERT_NEXT(a_run_cont, out_fire && !last_of_run_o, out_valid_o, "run broken")

  // an output that stays idle means the queue has space, so the input is not stalled
  `PFE_ASSERT(a_no_idle_stall, out_idle && $past(out_idle) |-> !in_stall_o, "stall while idle")

endmodule

bind playfair_stream_encryptor_core pfe_checker u_pfe_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the Playfair stream encryptor core. A short directed text set
// checks case folding, J to I, the three pair rules, repeats, X padding and
// end of text. Random text follows under varying sender idle and receiver
// stall. A local cipher model predicts every pair. A checker compares each
// delivered pair with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned SquareSide = 5;
  localparam logic [7:0]  FillerLetter = "X";
  localparam logic [8*25-1:0] KeyText = "MFHIKUNOPQZVWXYELARGDSTBC";
  localparam int unsigned RandomItemsPerPhase = 375;
  localparam int unsigned MaxReported = 10;

  typedef struct packed {
    logic [6:0] first;
    logic [6:0] second;
    logic       last;
  } cipher_pair_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_code_i = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [6:0] first_letter_o;
  logic [6:0] second_letter_o;
  logic       last_of_run_o;

  cipher_pair_t expected_pairs[$];
  logic [7:0]   held_letter = 8'h00;
  logic         held_valid = 1'b0;
  int unsigned  sender_idle_pct = 0;
  int unsigned  receiver_stall_pct = 0;
  int unsigned  mismatch_count = 0;

  playfair_stream_encryptor_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .first_letter_o (first_letter_o),
    .second_letter_o(second_letter_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Cipher model
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] square_letter(input int unsigned k);
    return KeyText[8*(SquareSide*SquareSide-1-k) +: 8];
  endfunction

  function automatic int unsigned square_cell(input logic [7:0] letter);
    for (int unsigned k = 0; k < SquareSide * SquareSide; k++) begin
      if (square_letter(k) == letter) return k;
    end
    return 0;
  endfunction

  function automatic logic is_alpha(input logic [7:0] code);
    return (code >= "a" && code <= "z") || (code >= "A" && code <= "Z");
  endfunction

  function automatic cipher_pair_t cipher_pair(input logic [7:0] a, input logic [7:0] b);
    cipher_pair_t pr;
    int unsigned  r1, c1, r2, c2;
    logic [7:0]   x, y;
    r1 = square_cell(a) / SquareSide;
    c1 = square_cell(a) % SquareSide;
    r2 = square_cell(b) / SquareSide;
    c2 = square_cell(b) % SquareSide;
    if (r1 == r2) begin
      x = square_letter(r1 * SquareSide + (c1 + 1) % SquareSide);
      y = square_letter(r2 * SquareSide + (c2 + 1) % SquareSide);
    end else if (c1 == c2) begin
      x = square_letter(((r1 + 1) % SquareSide) * SquareSide + c1);
      y = square_letter(((r2 + 1) % SquareSide) * SquareSide + c2);
    end else begin
      x = square_letter(r1 * SquareSide + c2);
      y = square_letter(r2 * SquareSide + c1);
    end
    pr.first  = x[6:0];
    pr.second = y[6:0];
    pr.last   = 1'b0;
    return pr;
  endfunction

  task automatic encipher_text_byte(input logic [7:0] code, input logic eot);
    logic [7:0]   c;
    cipher_pair_t fresh[$];
    c = code;
    if (c >= "a" && c <= "z") c = c - 8'h20;
    if (c == "J") c = "I";
    if (is_alpha(code)) begin
      if (!held_valid) begin
        held_letter = c;
        held_valid  = 1'b1;
      end else if (held_letter == c) begin
        // repeat: pad with X, the letter stays pending
        fresh.push_back(cipher_pair(held_letter, FillerLetter));
      end else begin
        fresh.push_back(cipher_pair(held_letter, c));
        held_letter = 8'h00;
        held_valid  = 1'b0;
      end
    end
    if (eot && held_valid) begin
      fresh.push_back(cipher_pair(held_letter, FillerLetter));
      held_letter = 8'h00;
      held_valid  = 1'b0;
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    foreach (fresh[i]) expected_pairs.push_back(fresh[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------
  task automatic send_text_byte(input logic [7:0] code, input logic eot);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_code_i   <= code;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    encipher_text_byte(code, eot);
  endtask

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReported) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    cipher_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pairs.size() == 0) begin
        log_mismatch($sformatf("unexpected pair %s%s last=%0b",
                     first_letter_o, second_letter_o, last_of_run_o));
      end else begin
        want = expected_pairs.pop_front();
        if (first_letter_o !== want.first || second_letter_o !== want.second ||
            last_of_run_o !== want.last) begin
          log_mismatch($sformatf("pair mismatch: expected %s%s last=%0b, got %s%s last=%0b",
                       want.first, want.second, want.last,
                       first_letter_o, second_letter_o, last_of_run_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_case_folding;
    send_text_byte("a", 1'b0);
    send_text_byte("Z", 1'b0);
    send_text_byte("z", 1'b0);
    send_text_byte("A", 1'b0);
  endtask

  task automatic test_non_letters;
    // hold Q pending across non-letter bytes, the extremes and those just outside the letter ranges, then pair with J
    send_text_byte("q", 1'b0);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'h40, 1'b0);
    send_text_byte(8'h5B, 1'b0);
    send_text_byte(8'h60, 1'b0);
    send_text_byte(8'h7B, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte("j", 1'b0);
  endtask

  task automatic test_pair_rules;
    send_text_byte("M", 1'b0);
    send_text_byte("K", 1'b0);
    send_text_byte("U", 1'b0);
    send_text_byte("m", 1'b0);
    send_text_byte("h", 1'b0);
    send_text_byte("Y", 1'b0);
  endtask

  task automatic test_repeats_and_padding;
    send_text_byte("X", 1'b0);
    send_text_byte("x", 1'b0);
    // non-letter at end of text still flushes the pending X
    send_text_byte(8'h20, 1'b1);
    send_text_byte(8'h2E, 1'b1);
    // repeat pair followed by the end-of-text pad
    send_text_byte("e", 1'b0);
    send_text_byte("E", 1'b1);
  endtask

  task automatic run_random_text(input int unsigned items);
    int unsigned counted;
    int unsigned pick;
    logic [7:0]  code;
    logic [7:0]  prev;
    logic        eot;
    counted = 0;
    prev    = "A";
    while (counted < items) begin
      pick = $urandom_range(99);
      if (pick < 45) code = 8'h41 + 8'($urandom_range(25));
      else if (pick < 80) code = 8'h61 + 8'($urandom_range(25));
      else if (pick < 90) code = prev ^ ($urandom_range(1) ? 8'h20 : 8'h00);
      else code = 8'($urandom_range(255));
      eot = ($urandom_range(99) < 8);
      if (is_alpha(code)) prev = code;
      if (is_alpha(code) || eot) counted++;
      send_text_byte(code, eot);
    end
  endtask

  task automatic test_random_steady;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random_text(RandomItemsPerPhase);
  endtask

  task automatic test_random_sender_idle;
    sender_idle_pct    = 87;
    receiver_stall_pct = 0;
    run_random_text(RandomItemsPerPhase);
  endtask

  task automatic test_random_receiver_stall;
    sender_idle_pct    = 0;
    receiver_stall_pct = 87;
    run_random_text(RandomItemsPerPhase);
  endtask

  task automatic test_random_both_idle;
    sender_idle_pct    = 29;
    receiver_stall_pct = 29;
    run_random_text(RandomItemsPerPhase);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_case_folding;
    test_non_letters;
    test_pair_rules;
    test_repeats_and_padding;
    test_random_steady;
    test_random_sender_idle;
    test_random_receiver_stall;
    test_random_both_idle;
    in_valid_i <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** playfair_stream_encryptor_core: PASSED **");
    end else begin
      $display("** playfair_stream_encryptor_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** playfair_stream_encryptor_core: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/pfe_pkg.sv
src/pfe_front.sv
src/pfe_queue.sv
src/pfe_back.sv
src/playfair_stream_encryptor_core.sv
src/pfe_checker.sv
bench/tb_top.sv
